// ----- rtl/sdiv_pkg.sv -----
// Shared types and constants for the pipelined signed restoring divider.
// No dependencies; every other file refers to this package by scoped names.
package sdiv_pkg;

  // Width of the dividend, divisor, quotient and remainder ports.
  localparam int PORT_WIDTH = 64;

  // Default datapath width; the low DATA_WIDTH bits of each operand are used.
  localparam int DATA_WIDTH_DEFAULT = 64;
  localparam int DATA_WIDTH_MIN = 8;

  // Quotient bits resolved in each pipeline stage.
  localparam int BITS_PER_STAGE = 2;

  // Control that travels down the pipeline beside the datapath words.
  typedef struct packed {
    logic valid;
    logic n_neg;
    logic d_neg;
    logic dbz;
  } ctl_t;

endpackage

// ----- rtl/sdiv_prep.sv -----
// Input stage: takes operand magnitudes and signs and flags a zero divisor.
// Depends on sdiv_pkg.
module sdiv_prep #(
  parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sdiv_pkg::PORT_WIDTH-1:0]   dividend,
  input  logic [sdiv_pkg::PORT_WIDTH-1:0]   divisor,
  output sdiv_pkg::ctl_t                    ctl,
  output logic [DATA_WIDTH-1:0]             n_mag,
  output logic [DATA_WIDTH-1:0]             d_mag
);

  logic [DATA_WIDTH-1:0] n_word;
  logic [DATA_WIDTH-1:0] d_word;

  assign n_word = dividend[DATA_WIDTH-1:0];
  assign d_word = divisor[DATA_WIDTH-1:0];

  // Magnitudes are unsigned, so the most negative value maps to 2^(DATA_WIDTH-1).
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= start;
    end
    ctl.n_neg <= n_word[DATA_WIDTH-1];
    ctl.d_neg <= d_word[DATA_WIDTH-1];
    ctl.dbz   <= (d_word == '0);
    n_mag     <= n_word[DATA_WIDTH-1] ? (~n_word + 1'b1) : n_word;
    d_mag     <= d_word[DATA_WIDTH-1] ? (~d_word + 1'b1) : d_word;
  end

endmodule

// ----- rtl/sdiv_stage.sv -----
// One pipeline stage of the restoring divider: resolves STEPS quotient bits.
// Depends on sdiv_pkg.
module sdiv_stage #(
  parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEFAULT,
  parameter int STEPS      = sdiv_pkg::BITS_PER_STAGE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sdiv_pkg::ctl_t        ctl_in,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] nq_in,
  input  logic [DATA_WIDTH-1:0] d_in,
  output sdiv_pkg::ctl_t        ctl_out,
  output logic [DATA_WIDTH-1:0] rem_out,
  output logic [DATA_WIDTH-1:0] nq_out,
  output logic [DATA_WIDTH-1:0] d_out
);

  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] nq_next;

  // nq holds the unconsumed dividend bits on top and the quotient bits
  // shifted in at the bottom.
  always_comb begin
    logic [DATA_WIDTH-1:0] rs;
    rem_next = rem_in;
    nq_next  = nq_in;
    for (int s = 0; s < STEPS; s++) begin
      rs      = {rem_next[DATA_WIDTH-2:0], nq_next[DATA_WIDTH-1]};
      nq_next = {nq_next[DATA_WIDTH-2:0], 1'b0};
      if (rs >= d_in) begin
        rem_next   = rs - d_in;
        nq_next[0] = 1'b1;
      end else begin
        rem_next = rs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.n_neg <= ctl_in.n_neg;
    ctl_out.d_neg <= ctl_in.d_neg;
    ctl_out.dbz   <= ctl_in.dbz;
    rem_out       <= rem_next;
    nq_out        <= nq_next;
    d_out         <= d_in;
  end

endmodule

// ----- rtl/sdiv_post.sv -----
// Output stage: restores signs, applies the zero-divisor result, sign-extends.
// Depends on sdiv_pkg.
module sdiv_post #(
  parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sdiv_pkg::ctl_t                          ctl,
  input  logic [DATA_WIDTH-1:0]                   q_mag,
  input  logic [DATA_WIDTH-1:0]                   r_mag,
  output logic                                    done,
  output logic signed [sdiv_pkg::PORT_WIDTH-1:0]  quotient,
  output logic signed [sdiv_pkg::PORT_WIDTH-1:0]  remainder,
  output logic                                    divide_by_zero
);

  logic signed [DATA_WIDTH-1:0] q_signed;
  logic signed [DATA_WIDTH-1:0] r_signed;

  // Quotient negates on differing signs; remainder follows the dividend.
  always_comb begin
    if (ctl.dbz) begin
      q_signed = '0;
      r_signed = '0;
    end else begin
      q_signed = (ctl.n_neg != ctl.d_neg) ? signed'(~q_mag + 1'b1) : signed'(q_mag);
      r_signed = ctl.n_neg ? signed'(~r_mag + 1'b1) : signed'(r_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    quotient       <= sdiv_pkg::PORT_WIDTH'(q_signed);
    remainder      <= sdiv_pkg::PORT_WIDTH'(r_signed);
    divide_by_zero <= ctl.dbz;
  end

endmodule

// ----- rtl/signed_restoring_divider_top.sv -----
// Top level of the pipelined signed restoring divider.
// Depends on sdiv_pkg, sdiv_prep, sdiv_stage and sdiv_post.
//
// Fully pipelined: a request is taken in every cycle that start is high (busy
// stays low), and its result appears with done high once it has passed the
// input register, every middle stage and the output register. One register
// stage handles signs and magnitudes, each of the middle stages resolves
// BITS_PER_STAGE quotient bits with a compare and subtract per bit, and a
// last stage restores signs. Results are held on the outputs for one cycle
// only; the receiver must take them as they come.
// A zero divisor gives zero quotient and remainder with divide_by_zero set.
module signed_restoring_divider_top #(
  parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [sdiv_pkg::PORT_WIDTH-1:0]  dividend,
  input  logic signed [sdiv_pkg::PORT_WIDTH-1:0]  divisor,
  output logic                                    done,
  output logic signed [sdiv_pkg::PORT_WIDTH-1:0]  quotient,
  output logic signed [sdiv_pkg::PORT_WIDTH-1:0]  remainder,
  output logic                                    divide_by_zero
);

  localparam int BPS        = sdiv_pkg::BITS_PER_STAGE;
  localparam int NUM_STAGES = (DATA_WIDTH + BPS - 1) / BPS;
  localparam int LATENCY    = NUM_STAGES + 2;

  sdiv_pkg::ctl_t        ctl_q [0:NUM_STAGES];
  logic [DATA_WIDTH-1:0] rem_q [0:NUM_STAGES];
  logic [DATA_WIDTH-1:0] nq_q  [0:NUM_STAGES];
  logic [DATA_WIDTH-1:0] d_q   [0:NUM_STAGES];

  // The pipeline never stalls.
  assign busy = 1'b0;

  sdiv_prep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (dividend),
    .divisor  (divisor),
    .ctl      (ctl_q[0]),
    .n_mag    (nq_q[0]),
    .d_mag    (d_q[0])
  );

  assign rem_q[0] = '0;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    localparam int LEFT  = DATA_WIDTH - k * BPS;
    localparam int STEPS = (LEFT < BPS) ? LEFT : BPS;

    sdiv_stage #(
      .DATA_WIDTH(DATA_WIDTH),
      .STEPS     (STEPS)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_q[k]),
      .rem_in  (rem_q[k]),
      .nq_in   (nq_q[k]),
      .d_in    (d_q[k]),
      .ctl_out (ctl_q[k+1]),
      .rem_out (rem_q[k+1]),
      .nq_out  (nq_q[k+1]),
      .d_out   (d_q[k+1])
    );
  end

  sdiv_post #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_post (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl_q[NUM_STAGES]),
    .q_mag          (nq_q[NUM_STAGES]),
    .r_mag          (rem_q[NUM_STAGES]),
    .done           (done),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

  // Every result traces back to a matching accepted request.
  a_done_follows_request : assert property (
    @(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY)
  ) else $error("result without a matching request");

  a_dbz_zero : assert property (
    @(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (quotient == '0 && remainder == '0)
  ) else $error("divide by zero result not cleared");

  a_dbz_matches_divisor : assert property (
    @(posedge clk) disable iff (rst)
    done |-> (divide_by_zero == $past(divisor[DATA_WIDTH-1:0] == '0, LATENCY))
  ) else $error("divide by zero flag does not match divisor");

  // A nonzero remainder carries the dividend's sign.
  a_rem_sign : assert property (
    @(posedge clk) disable iff (rst)
    (done && remainder != '0) |->
      (remainder[sdiv_pkg::PORT_WIDTH-1] == $past(dividend[DATA_WIDTH-1], LATENCY))
  ) else $error("remainder sign differs from dividend sign");

endmodule
